// ----- sv/bcdq_pkg.sv -----
`default_nettype none

package bcdq_pkg;

    typedef enum logic [2:0] {
        MODE_INS_FRONT = 3'd0,
        MODE_INS_BACK  = 3'd1,
        MODE_DEL_FRONT = 3'd2,
        MODE_DEL_BACK  = 3'd3,
        MODE_DEL_POS   = 3'd4,
        MODE_COUNT     = 3'd5,
        MODE_LIST      = 3'd6
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_FULL   = 2'd2,
        ST_BADPOS = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_LIST_RD,
        S_LIST_EMIT,
        S_REPLY
    } state_t;

    localparam int unsigned WORD_W  = 32;
    localparam int unsigned POS_W   = 6;
    localparam int unsigned CNT_W   = 6;
    localparam int unsigned CMP_W   = 8;

endpackage

`default_nettype wire

// ----- sv/bcdq_ram.sv -----
`default_nettype none

module bcdq_ram #(
    parameter int DEPTH  = 32,
    parameter int DATA_W = 32,
    parameter int ADDR_W = 5
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read data holds until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- sv/bounded_circular_deque_core.sv -----
`default_nettype none

// Bounded deque of CAPACITY signed 32-bit words in a circular buffer.
// Request channel (req_valid / req_stall) carries mode, value, position;
// a word is taken when req_valid is high and req_stall is low. The block
// holds req_stall high from acceptance until its final result has been
// loaded into the output register.
// Response channel (rsp_valid / rsp_stall) carries entry_value,
// entry_count, status and last; every request gives one response word,
// except a list of a non-empty store, which gives one word per entry
// from the front with last set on the final one.
// Insert, delete at either end, count and an empty list go through
// S_REPLY to the output register. Positional delete closes up the
// entries behind the deleted one through a single RAM port pair, each
// moved entry read in S_SHIFT_RD and written in S_SHIFT_WR. Listing
// reads each entry in S_LIST_RD and emits it in S_LIST_EMIT. All slot
// indexes come from one shared wrap adder. A stalled response word holds
// in the output register; the sequencer waits until it is taken. Reset
// empties the store at once (no clearing pass); the RAM is not reset.
module bounded_circular_deque_core #(
    parameter int CAPACITY = 32
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_stall,
    input  wire logic [2:0]         mode,
    input  wire logic signed [31:0] value,
    input  wire logic [5:0]         position,
    output logic                    rsp_valid,
    input  wire logic               rsp_stall,
    output logic signed [31:0]      entry_value,
    output logic [5:0]              entry_count,
    output logic [1:0]              status,
    output logic                    last
);

    import bcdq_pkg::*;

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    state_t              state_reg, state_next;
    logic [IW-1:0]       front_reg, front_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [IW-1:0]       off_reg, off_next;
    logic [IW-1:0]       wr_addr_reg, wr_addr_next;
    logic [IW-1:0]       nxt_addr_reg, nxt_addr_next;
    status_t             status_reg, status_next;

    logic                rsp_valid_reg, rsp_valid_next;
    logic [WORD_W-1:0]   rsp_value_reg, rsp_value_next;
    logic [CNT_W-1:0]    rsp_count_reg, rsp_count_next;
    status_t             rsp_status_reg, rsp_status_next;
    logic                rsp_last_reg, rsp_last_next;

    logic                ram_wr_en;
    logic [IW-1:0]       ram_wr_addr;
    logic [WORD_W-1:0]   ram_wr_data;
    logic                ram_rd_en;
    logic [IW-1:0]       ram_rd_addr;
    logic [WORD_W-1:0]   ram_rd_data;

    logic [IW-1:0]       slot_off;
    logic [IW:0]         slot_sum;
    logic [IW-1:0]       slot_out;

    logic [CW+5:0]       cnt_ext;
    logic                out_free;
    logic                is_full;
    logic                is_empty;
    logic                pos_bad;
    logic                shift_more;
    logic                list_end;

    bcdq_ram #(
        .DEPTH  (CAPACITY),
        .DATA_W (WORD_W),
        .ADDR_W (IW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // shared wrap adder: slot(off) = (front + off) mod CAPACITY
    always_comb
    begin
        slot_off = '0;
        case (state_reg)
            S_IDLE:
            begin
                case (mode)
                    MODE_INS_FRONT: slot_off = IW'(CAPACITY - 1);
                    MODE_INS_BACK:  slot_off = IW'(count_reg);
                    MODE_DEL_FRONT: slot_off = IW'(1);
                    MODE_DEL_POS:   slot_off = IW'(position - 6'd1);
                    default:        slot_off = '0;
                endcase
            end
            S_SHIFT_RD: slot_off = off_reg;
            S_LIST_RD:  slot_off = off_reg;
            default:    slot_off = '0;
        endcase
    end

    assign slot_sum = {1'b0, front_reg} + {1'b0, slot_off};
    assign slot_out = (slot_sum >= (IW+1)'(CAPACITY)) ?
                      IW'(slot_sum - (IW+1)'(CAPACITY)) : IW'(slot_sum);

    assign cnt_ext    = {6'd0, count_reg};
    assign out_free   = !rsp_valid_reg || !rsp_stall;
    assign is_full    = (count_reg == CW'(CAPACITY));
    assign is_empty   = (count_reg == '0);
    assign pos_bad    = (position == '0) || (CMP_W'(position) > CMP_W'(count_reg));
    assign shift_more = ((CMP_W'(off_reg) + CMP_W'(1)) < CMP_W'(count_reg));
    assign list_end   = ((CMP_W'(off_reg) + CMP_W'(1)) == CMP_W'(count_reg));

    always_comb
    begin
        state_next      = state_reg;
        front_next      = front_reg;
        count_next      = count_reg;
        off_next        = off_reg;
        wr_addr_next    = wr_addr_reg;
        nxt_addr_next   = nxt_addr_reg;
        status_next     = status_reg;
        rsp_valid_next  = rsp_valid_reg && rsp_stall;
        rsp_value_next  = rsp_value_reg;
        rsp_count_next  = rsp_count_reg;
        rsp_status_next = rsp_status_reg;
        rsp_last_next   = rsp_last_reg;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = slot_out;
        ram_wr_data     = value;
        ram_rd_en       = 1'b0;
        ram_rd_addr     = slot_out;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    status_next = ST_OK;
                    state_next  = S_REPLY;
                    case (mode)
                        MODE_INS_FRONT:
                        begin
                            if (is_full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                front_next = slot_out;
                                ram_wr_en  = 1'b1;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        MODE_INS_BACK:
                        begin
                            if (is_full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                ram_wr_en  = 1'b1;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        MODE_DEL_FRONT:
                        begin
                            if (is_empty)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                front_next = slot_out;
                                count_next = count_reg - CW'(1);
                            end
                        end
                        MODE_DEL_BACK:
                        begin
                            if (is_empty)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                count_next = count_reg - CW'(1);
                            end
                        end
                        MODE_DEL_POS:
                        begin
                            if (is_empty)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else if (pos_bad)
                            begin
                                status_next = ST_BADPOS;
                            end
                            else if (CMP_W'(position) < CMP_W'(count_reg))
                            begin
                                // close up: entry at offset i+1 moves to i
                                wr_addr_next = slot_out;
                                off_next     = IW'(position);
                                state_next   = S_SHIFT_RD;
                            end
                            else
                            begin
                                count_next = count_reg - CW'(1);
                            end
                        end
                        MODE_LIST:
                        begin
                            if (is_empty)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                off_next   = '0;
                                state_next = S_LIST_RD;
                            end
                        end
                        default:
                        begin
                            status_next = ST_OK;
                        end
                    endcase
                end
            end

            S_SHIFT_RD:
            begin
                ram_rd_en     = 1'b1;
                nxt_addr_next = slot_out;
                state_next    = S_SHIFT_WR;
            end

            S_SHIFT_WR:
            begin
                ram_wr_en    = 1'b1;
                ram_wr_addr  = wr_addr_reg;
                ram_wr_data  = ram_rd_data;
                wr_addr_next = nxt_addr_reg;
                off_next     = off_reg + IW'(1);
                if (shift_more)
                begin
                    state_next = S_SHIFT_RD;
                end
                else
                begin
                    count_next = count_reg - CW'(1);
                    state_next = S_REPLY;
                end
            end

            S_LIST_RD:
            begin
                ram_rd_en  = 1'b1;
                state_next = S_LIST_EMIT;
            end

            S_LIST_EMIT:
            begin
                if (out_free)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_value_next  = ram_rd_data;
                    rsp_count_next  = cnt_ext[5:0];
                    rsp_status_next = ST_OK;
                    rsp_last_next   = list_end;
                    if (list_end)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        off_next   = off_reg + IW'(1);
                        state_next = S_LIST_RD;
                    end
                end
            end

            S_REPLY:
            begin
                if (out_free)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_value_next  = '0;
                    rsp_count_next  = cnt_ext[5:0];
                    rsp_status_next = status_reg;
                    rsp_last_next   = 1'b1;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            front_reg     <= '0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            front_reg     <= front_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        off_reg        <= off_next;
        wr_addr_reg    <= wr_addr_next;
        nxt_addr_reg   <= nxt_addr_next;
        status_reg     <= status_next;
        rsp_value_reg  <= rsp_value_next;
        rsp_count_reg  <= rsp_count_next;
        rsp_status_reg <= rsp_status_next;
        rsp_last_reg   <= rsp_last_next;
    end

    assign req_stall   = (state_reg != S_IDLE);
    assign rsp_valid   = rsp_valid_reg;
    assign entry_value = rsp_value_reg;
    assign entry_count = rsp_count_reg;
    assign status      = rsp_status_reg;
    assign last        = rsp_last_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        CMP_W'(count_reg) <= CMP_W'(CAPACITY))
    else $error("stored count above capacity");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        ##1 (count_reg == $past(count_reg) ||
             count_reg == $past(count_reg) + CW'(1) ||
             count_reg == $past(count_reg) - CW'(1)))
    else $error("stored count moved by more than one");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && status == ST_EMPTY) |-> (entry_count == '0))
    else $error("empty status with nonzero count");

    a_full_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && is_full && ram_wr_en) |-> 1'b0)
    else $error("write into a full store");

endmodule

`default_nettype wire

// ----- tb/bcdq_checker.sv -----
`timescale 1ns / 100ps

module bcdq_checker #(
    parameter int CAPACITY = 32
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    input  wire logic               req_stall,
    input  wire logic [2:0]         mode,
    input  wire logic signed [31:0] value,
    input  wire logic [5:0]         position,
    input  wire logic               rsp_valid,
    input  wire logic               rsp_stall,
    input  wire logic signed [31:0] entry_value,
    input  wire logic [5:0]         entry_count,
    input  wire logic [1:0]         status,
    input  wire logic               last,
    output int                      fail_count,
    output int                      pending,
    output int                      words_checked
);
    import bcdq_pkg::*;

    localparam int PRINT_CAP = 40;

    typedef struct packed {
        logic signed [31:0] word;
        logic [5:0]         count;
        status_t            st;
        logic               fin;
    } reply_t;

    reply_t             replies_due [$];
    logic signed [31:0] ring [CAPACITY];
    int unsigned        head_idx;
    int unsigned        fill;

    function automatic int unsigned slot_of(input int unsigned offset);
        return (head_idx + offset) % CAPACITY;
    endfunction

    // every reply word carries the occupancy after the request
    function automatic void push_reply(input logic signed [31:0] word, input status_t st,
                                       input logic fin);
        reply_t r;
        r.word  = word;
        r.count = fill[5:0];
        r.st    = st;
        r.fin   = fin;
        replies_due.push_back(r);
    endfunction

    task automatic run_deque_op(input logic [2:0] op, input logic signed [31:0] word,
                                input logic [5:0] pos);
        status_t     st;
        int unsigned i;
        st = ST_OK;
        if (op == MODE_LIST)
        begin
            if (fill == 0)
                push_reply('0, ST_EMPTY, 1'b1);
            else
                for (i = 0; i < fill; i++)
                    push_reply(ring[slot_of(i)], ST_OK, (i + 1 == fill));
        end
        else
        begin
            case (op)
                MODE_INS_FRONT:
                    if (fill >= CAPACITY)
                        st = ST_FULL;
                    else
                    begin
                        head_idx       = (head_idx + CAPACITY - 1) % CAPACITY;
                        ring[head_idx] = word;
                        fill++;
                    end
                MODE_INS_BACK:
                    if (fill >= CAPACITY)
                        st = ST_FULL;
                    else
                    begin
                        ring[slot_of(fill)] = word;
                        fill++;
                    end
                MODE_DEL_FRONT:
                    if (fill == 0)
                        st = ST_EMPTY;
                    else
                    begin
                        head_idx = slot_of(1);
                        fill--;
                    end
                MODE_DEL_BACK:
                    if (fill == 0)
                        st = ST_EMPTY;
                    else
                        fill--;
                MODE_DEL_POS:
                    if (fill == 0)
                        st = ST_EMPTY;
                    else if (pos == 0 || pos > fill)
                        st = ST_BADPOS;
                    else
                    begin
                        // entries behind the hole close up toward the front
                        for (i = pos - 1; i + 1 < fill; i++)
                            ring[slot_of(i)] = ring[slot_of(i + 1)];
                        fill--;
                    end
                default:
                    ;
            endcase
            push_reply('0, st, 1'b1);
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (fail_count < PRINT_CAP)
            $display("ERROR reply word %0d: %s got 0x%0h, want 0x%0h",
                     words_checked, what, got, want);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        reply_t due;
        if (!rst_n)
        begin
            replies_due.delete();
            head_idx      = 0;
            fill          = 0;
            fail_count    = 0;
            words_checked = 0;
            pending       = 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (replies_due.size() == 0)
                    report_mismatch("word with nothing pending", entry_value, '0);
                else
                begin
                    due = replies_due.pop_front();
                    if (entry_value !== due.word)
                        report_mismatch("entry_value", entry_value, due.word);
                    if (entry_count !== due.count)
                        report_mismatch("entry_count", entry_count, due.count);
                    if (status !== due.st)
                        report_mismatch("status", status, due.st);
                    if (last !== due.fin)
                        report_mismatch("last", last, due.fin);
                end
                words_checked++;
            end
            if (req_valid && !req_stall)
                run_deque_op(mode, value, position);
            pending = replies_due.size();
        end
    end

endmodule

// ----- tb/bounded_circular_deque_core_tb.sv -----
`timescale 1ns / 100ps

module bounded_circular_deque_core_tb;
    import bcdq_pkg::*;

    localparam int         CAPACITY     = 32;
    localparam int         RANDOM_ITEMS = 100;
    localparam int         CYCLE_LIMIT  = 500000;
    localparam int         DRAIN_CYCLES = 100;
    localparam int         HOLD_AFTER   = 60;
    localparam int         HOLD_CYCLES  = 400;
    localparam logic [2:0] MODE_UNUSED  = 3'd7;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               req_valid = 1'b0;
    logic               req_stall;
    logic [2:0]         mode      = '0;
    logic signed [31:0] value     = '0;
    logic [5:0]         position  = '0;
    logic               rsp_valid;
    logic               rsp_stall = 1'b1;
    logic signed [31:0] entry_value;
    logic [5:0]         entry_count;
    logic [1:0]         status;
    logic               last;

    int fail_count;
    int pending;
    int words_checked;
    int cycles        = 0;
    int occupancy     = 0;
    int items_sent    = 0;
    int tx_steady     = 0;
    int sent_by_mode [8];

    always #5 clk = ~clk;

    always @(posedge clk)
        cycles <= cycles + 1;

    bounded_circular_deque_core #(
        .CAPACITY (CAPACITY)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .mode        (mode),
        .value       (value),
        .position    (position),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .entry_value (entry_value),
        .entry_count (entry_count),
        .status      (status),
        .last        (last)
    );

    bcdq_checker #(
        .CAPACITY (CAPACITY)
    ) i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_stall     (req_stall),
        .mode          (mode),
        .value         (value),
        .position      (position),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .entry_value   (entry_value),
        .entry_count   (entry_count),
        .status        (status),
        .last          (last),
        .fail_count    (fail_count),
        .pending       (pending),
        .words_checked (words_checked)
    );

    function automatic logic signed [31:0] pick_word();
        case ($urandom_range(0, 11))
            0:       return 32'sh7fffffff;
            1:       return 32'sh80000000;
            2:       return '0;
            3:       return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_word(input logic [2:0] op, input logic signed [31:0] word,
                             input logic [5:0] pos);
        int gap;
        if (tx_steady > 0)
        begin
            tx_steady--;
            gap = 0;
        end
        else
        begin
            gap = $urandom_range(0, 10);
            if ($urandom_range(0, 12) == 0)
                tx_steady = $urandom_range(4, 16);
        end
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        mode      <= op;
        value     <= word;
        position  <= pos;
        do @(posedge clk); while (!(req_valid && !req_stall));
        sent_by_mode[op]++;
        items_sent++;
        // rough fill level, only used to aim positions and bursts
        case (op)
            MODE_INS_FRONT, MODE_INS_BACK:
                if (occupancy < CAPACITY)
                    occupancy++;
            MODE_DEL_FRONT, MODE_DEL_BACK:
                if (occupancy > 0)
                    occupancy--;
            MODE_DEL_POS:
                if (pos >= 1 && pos <= occupancy)
                    occupancy--;
            default:
                ;
        endcase
    endtask

    function automatic logic [5:0] good_pos();
        return (occupancy > 0) ? 6'($urandom_range(1, occupancy)) : 6'd1;
    endfunction

    // response side: random hold-off per word, one long stall to back up the request side
    initial
    begin : rsp_side
        int gap;
        int steady;
        int taken;
        steady = 0;
        taken  = 0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (taken == HOLD_AFTER)
            begin
                rsp_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                if (steady > 0)
                begin
                    steady--;
                    gap = 0;
                end
                else
                begin
                    gap = $urandom_range(0, 10);
                    if ($urandom_range(0, 12) == 0)
                        steady = $urandom_range(4, 20);
                end
                if (gap > 0)
                begin
                    rsp_stall <= 1'b1;
                    repeat (gap) @(posedge clk);
                end
            end
            rsp_stall <= 1'b0;
            do @(posedge clk); while (!(rsp_valid && !rsp_stall));
            taken++;
        end
    end

    initial
    begin : watchdog
        wait (cycles >= CYCLE_LIMIT);
        $display("TIMEOUT after %0d cycles, %0d reply words pending", cycles, pending);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin : stimulus
        int kind;
        int n;
        int k;
        int directed_items;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty store corner cases, then inserts at both ends and a list
        send_word(MODE_LIST, '0, 6'd0);
        send_word(MODE_DEL_FRONT, $urandom, 6'd0);
        send_word(MODE_DEL_BACK, $urandom, 6'd0);
        send_word(MODE_DEL_POS, '0, 6'd1);
        send_word(MODE_COUNT, '0, 6'd0);
        send_word(MODE_INS_FRONT, 32'sh7fffffff, 6'd0);
        send_word(MODE_INS_BACK, 32'sh80000000, 6'd63);
        send_word(MODE_INS_FRONT, -32'sd1, 6'd0);
        send_word(MODE_INS_BACK, '0, 6'd0);
        send_word(MODE_LIST, '0, 6'd0);
        // bad positions, then the tail by position, then the head
        send_word(MODE_DEL_POS, '0, 6'd0);
        send_word(MODE_DEL_POS, '0, 6'd63);
        send_word(MODE_DEL_POS, '0, 6'd5);
        send_word(MODE_DEL_POS, '0, 6'd4);
        send_word(MODE_UNUSED, $urandom, 6'($urandom));
        send_word(MODE_DEL_POS, '0, 6'd1);
        send_word(MODE_LIST, '0, 6'd0);
        send_word(MODE_DEL_FRONT, '0, 6'd0);
        send_word(MODE_DEL_BACK, '0, 6'd0);
        send_word(MODE_COUNT, '0, 6'd0);
        directed_items = items_sent - sent_by_mode[MODE_UNUSED];

        // fill to capacity, push against full, longest list and longest close-up
        while (occupancy < CAPACITY)
            send_word($urandom_range(0, 1) ? MODE_INS_BACK : MODE_INS_FRONT, pick_word(),
                      6'($urandom));
        send_word(MODE_INS_FRONT, pick_word(), 6'd0);
        send_word(MODE_INS_BACK, pick_word(), 6'd0);
        send_word(MODE_LIST, '0, 6'd0);
        send_word(MODE_DEL_POS, '0, 6'd1);
        send_word(MODE_DEL_POS, '0, 6'(occupancy));
        send_word(MODE_DEL_POS, '0, 6'(occupancy + 1));
        send_word(MODE_LIST, '0, 6'd0);

        while (items_sent - sent_by_mode[MODE_UNUSED] < directed_items + RANDOM_ITEMS)
        begin
            kind = $urandom_range(0, 9);
            if (kind < 3)
            begin
                n = $urandom_range(1, 10);
                for (k = 0; k < n; k++)
                    send_word($urandom_range(0, 1) ? MODE_INS_BACK : MODE_INS_FRONT,
                              pick_word(), 6'($urandom));
            end
            else if (kind < 5)
            begin
                n = $urandom_range(1, 6);
                for (k = 0; k < n; k++)
                    case ($urandom_range(0, 2))
                        0:       send_word(MODE_DEL_FRONT, $urandom, 6'($urandom));
                        1:       send_word(MODE_DEL_BACK, $urandom, 6'($urandom));
                        default: send_word(MODE_DEL_POS, $urandom, good_pos());
                    endcase
            end
            else if (kind < 7)
                send_word(MODE_DEL_POS, $urandom, good_pos());
            else if (kind == 7)
                send_word($urandom_range(0, 1) ? MODE_LIST : MODE_COUNT, $urandom,
                          6'($urandom));
            else
                send_word(3'($urandom_range(0, 6)), $urandom, 6'($urandom_range(0, 63)));
        end
        req_valid <= 1'b0;

        do @(posedge clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d requests: %0d front/%0d back inserts, %0d front/%0d back deletes,",
                 items_sent, sent_by_mode[MODE_INS_FRONT], sent_by_mode[MODE_INS_BACK],
                 sent_by_mode[MODE_DEL_FRONT], sent_by_mode[MODE_DEL_BACK]);
        $display("%0d positional deletes, %0d counts, %0d lists; %0d reply words checked",
                 sent_by_mode[MODE_DEL_POS], sent_by_mode[MODE_COUNT],
                 sent_by_mode[MODE_LIST], words_checked);
        if (fail_count == 0 && pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
